### hw/rtl/sdspi_pkg.sv
// Package: shared types, codes and CRC7 helper for the SPI-mode SD host sequencer.
`timescale 1ns / 1ps
package sdspi_pkg;
	localparam int BLOCK_BYTES_DEF   = 512;
	localparam int POWERUP_BYTES_DEF = 10;

	localparam logic [1:0] CMD_INIT = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_BYTE = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	localparam logic [2:0] ACT_XCHG = 3'd0;
	localparam logic [2:0] ACT_CS   = 3'd1;
	localparam logic [2:0] ACT_SPD  = 3'd2;
	localparam logic [2:0] ACT_PAY  = 3'd3;
	localparam logic [2:0] ACT_FIN  = 3'd4;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_PARAM   = 4'd1;
	localparam logic [3:0] ST_BUS     = 4'd2;
	localparam logic [3:0] ST_NOINIT  = 4'd3;
	localparam logic [3:0] ST_CMD0    = 4'd4;
	localparam logic [3:0] ST_PATTERN = 4'd5;
	localparam logic [3:0] ST_ACMD41  = 4'd6;
	localparam logic [3:0] ST_CMD58   = 4'd7;
	localparam logic [3:0] ST_CMD16   = 4'd8;
	localparam logic [3:0] ST_VOLT    = 4'd9;
	localparam logic [3:0] ST_READCMD = 4'd10;
	localparam logic [3:0] ST_TOKEN   = 4'd11;
	localparam logic [3:0] ST_TIMEOUT = 4'd12;

	localparam logic [2:0] REG_RESP_LIMIT = 3'd0;
	localparam logic [2:0] REG_IDLE_TRIES = 3'd1;
	localparam logic [2:0] REG_INIT_TMO   = 3'd2;
	localparam logic [2:0] REG_TOKEN_TMO  = 3'd3;
	localparam logic [2:0] REG_BUSY_TMO   = 3'd4;

	localparam logic [5:0] SD_CMD0  = 6'd0;
	localparam logic [5:0] SD_CMD8  = 6'd8;
	localparam logic [5:0] SD_CMD12 = 6'd12;
	localparam logic [5:0] SD_CMD16 = 6'd16;
	localparam logic [5:0] SD_CMD17 = 6'd17;
	localparam logic [5:0] SD_CMD18 = 6'd18;
	localparam logic [5:0] SD_CMD41 = 6'd41;
	localparam logic [5:0] SD_CMD55 = 6'd55;
	localparam logic [5:0] SD_CMD58 = 6'd58;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b0000000001,
		PH_POWERUP = 10'b0000000010,
		PH_CMD_TX  = 10'b0000000100,
		PH_STUFF   = 10'b0000001000,
		PH_RESP    = 10'b0000010000,
		PH_TAIL    = 10'b0000100000,
		PH_DESEL   = 10'b0001000000,
		PH_TOKEN   = 10'b0010000000,
		PH_DATA    = 10'b0100000000,
		PH_BUSY    = 10'b1000000000
	} phase_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       level;
		logic [7:0] payload;
		logic [3:0] status;
		logic [1:0] card_kind;
	} res_t;

	typedef struct packed {
		logic [2:0] n;
		res_t       r0;
		res_t       r1;
		res_t       r2;
		res_t       r3;
	} res_set_t;

	localparam int MAX_RES = 4;

	// CRC7 over the 40-bit command head, polynomial x^7 + x^3 + 1
	function automatic logic [6:0] crc7(input logic [39:0] head);
		logic [7:0] c;
		c = 8'd0;
		for (int i = 39; i >= 0; i--) begin
			c = {c[6:0], 1'b0};
			if (head[i] ^ c[7]) c = c ^ 8'h09;
		end
		return c[6:0];
	endfunction
endpackage

### hw/rtl/sdspi_seq.sv
// Sequencer step: next state and up to four result items for one transaction.
`timescale 1ns / 1ps
module sdspi_seq #(
	parameter int BLOCK_BYTES   = sdspi_pkg::BLOCK_BYTES_DEF,
	parameter int POWERUP_BYTES = sdspi_pkg::POWERUP_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          command,
	input  logic [31:0]         block_address,
	input  logic [15:0]         block_count,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          response_limit,
	input  logic [7:0]          idle_attempts,
	input  logic [15:0]         init_timeout_ms,
	input  logic [15:0]         token_timeout_ms,
	input  logic [15:0]         busy_tmo,
	output sdspi_pkg::res_set_t res
);
	import sdspi_pkg::*;

	localparam int BW = 10;
	localparam logic [BW-1:0] BB      = BW'(BLOCK_BYTES);
	localparam logic [BW-1:0] BB2     = BW'(BLOCK_BYTES + 2);
	localparam logic [BW-1:0] PUB     = BW'(POWERUP_BYTES);
	localparam logic [31:0]   BB32    = 32'(BLOCK_BYTES);
	localparam int            SH      = $clog2(BLOCK_BYTES);

	phase_t        phase_q, ph_n;
	logic [BW-1:0] idx_q, idx_n;
	logic [47:0]   frame_q, frame_n;
	logic [7:0]    att_q, att_n, scan_q, scan_n;
	logic [15:0]   ms_q, ms_n;
	logic [31:0]   tail_q, tail_n;
	logic          v2_q, v2_n, blk_q, blk_n, rdy_q, rdy_n;
	logic [15:0]   left_q, left_n;
	logic [3:0]    pend_q, pend_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			frame_q <= '0;
			att_q   <= '0;
			scan_q  <= '0;
			ms_q    <= '0;
			tail_q  <= '0;
			v2_q    <= 1'b0;
			blk_q   <= 1'b0;
			rdy_q   <= 1'b0;
			left_q  <= '0;
			pend_q  <= '0;
		end else if (step) begin
			phase_q <= ph_n;
			idx_q   <= idx_n;
			frame_q <= frame_n;
			att_q   <= att_n;
			scan_q  <= scan_n;
			ms_q    <= ms_n;
			tail_q  <= tail_n;
			v2_q    <= v2_n;
			blk_q   <= blk_n;
			rdy_q   <= rdy_n;
			left_q  <= left_n;
			pend_q  <= pend_n;
		end
	end

	always_comb begin
		res_t        rr [MAX_RES];
		logic [2:0]  n;
		logic [5:0]  cc;
		logic [7:0]  r1v;
		logic        do_r1, do_desel, do_tail_chk;
		logic        sc_cmd;
		logic [5:0]  sc_id;
		logic [31:0] sc_arg;
		logic        sc_sel;
		logic        do_fin, do_fin_init;
		logic [3:0]  fin_st;
		logic [7:0]  lim;
		logic [39:0] head;
		logic        kind_rdy;
		logic [BW-1:0] ib;

		ph_n = phase_q; idx_n = idx_q; frame_n = frame_q; att_n = att_q;
		scan_n = scan_q; ms_n = ms_q; tail_n = tail_q; v2_n = v2_q; blk_n = blk_q;
		rdy_n = rdy_q; left_n = left_q; pend_n = pend_q;
		for (int k = 0; k < MAX_RES; k++) rr[k] = '0;
		n = 3'd0;
		cc = frame_q[45:40];
		r1v = rx_byte;
		do_r1 = 1'b0; do_desel = 1'b0; do_tail_chk = 1'b0;
		sc_cmd = 1'b0; sc_id = SD_CMD0; sc_arg = '0; sc_sel = 1'b0;
		do_fin = 1'b0; do_fin_init = 1'b0; fin_st = ST_OK;
		lim = 8'd1; head = '0; kind_rdy = rdy_q; ib = '0;

		unique case (command)
		CMD_TICK: begin
			if (ms_q != 16'hFFFF) ms_n = ms_q + 16'd1;
		end
		CMD_INIT, CMD_READ: begin
			if (phase_q == PH_IDLE) begin
				if (command == CMD_INIT) begin
					v2_n = 1'b0; blk_n = 1'b0; rdy_n = 1'b0; pend_n = ST_OK;
					att_n = '0; ms_n = '0;
					rr[0].action = ACT_SPD;
					rr[1].action = ACT_CS;
					rr[2].action = ACT_XCHG; rr[2].tx_byte = 8'hFF;
					n = 3'd3;
					idx_n = BW'(1);
					ph_n = PH_POWERUP;
				end else if (block_count == 16'd0) begin
					do_fin = 1'b1; fin_st = ST_PARAM;
				end else if (!rdy_q) begin
					do_fin = 1'b1; fin_st = ST_NOINIT;
				end else begin
					left_n = block_count; pend_n = ST_OK;
					sc_cmd = 1'b1; sc_sel = 1'b1;
					sc_id = (block_count == 16'd1) ? SD_CMD17 : SD_CMD18;
					sc_arg = blk_q ? block_address : (block_address << SH);
				end
			end
		end
		default: begin
			unique case (phase_q)
			PH_IDLE: ;
			PH_POWERUP: begin
				if (idx_q < PUB) begin
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
					idx_n = idx_q + BW'(1);
				end else begin
					att_n = '0; sc_cmd = 1'b1; sc_sel = 1'b1; sc_id = SD_CMD0;
				end
			end
			PH_CMD_TX: begin
				if (idx_q < BW'(7)) begin
					ib = idx_q - BW'(1);
					rr[0].action = ACT_XCHG;
					rr[0].tx_byte = frame_q[47 - 8*ib[2:0] -: 8];
					n = 3'd1;
					idx_n = idx_q + BW'(1);
				end else begin
					ph_n = (cc == SD_CMD12) ? PH_STUFF : PH_RESP;
					if (cc != SD_CMD12) scan_n = '0;
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end
			end
			PH_STUFF: begin
				ph_n = PH_RESP; scan_n = '0;
				rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
			end
			PH_RESP: begin
				lim = (response_limit == 8'd0) ? 8'd1 : response_limit;
				if (!rx_byte[7]) begin
					do_r1 = 1'b1;
				end else begin
					scan_n = scan_q + 8'd1;
					if (scan_n >= lim) begin
						do_r1 = 1'b1; r1v = 8'hFF;
					end else begin
						rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
					end
				end
			end
			PH_TAIL: begin
				tail_n = {tail_q[23:0], rx_byte};
				idx_n = idx_q + BW'(1);
				if (idx_n < BW'(4)) begin
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end else do_tail_chk = 1'b1;
			end
			PH_DESEL: begin
				unique case (cc)
				SD_CMD0: begin
					if (tail_q == 32'h1) begin
						pend_n = ST_OK; sc_cmd = 1'b1; sc_sel = 1'b1;
						sc_id = SD_CMD8; sc_arg = 32'h000001AA;
					end else begin
						att_n = att_q + 8'd1;
						lim = (idle_attempts == 8'd0) ? 8'd1 : idle_attempts;
						if (att_n >= lim) begin
							do_fin_init = 1'b1; fin_st = ST_CMD0;
						end else begin
							sc_cmd = 1'b1; sc_sel = 1'b1; sc_id = SD_CMD0;
						end
					end
				end
				SD_CMD8: begin
					if (pend_q != ST_OK) begin
						do_fin_init = 1'b1; fin_st = pend_q;
					end else begin
						ms_n = '0; sc_cmd = 1'b1; sc_sel = 1'b1; sc_id = SD_CMD55;
					end
				end
				SD_CMD55: begin
					do_fin_init = 1'b1; fin_st = ST_BUS;
				end
				SD_CMD41: begin
					if (tail_q == 32'h0) begin
						sc_cmd = 1'b1; sc_sel = 1'b1;
						if (v2_q) sc_id = SD_CMD58;
						else begin
							blk_n = 1'b0; sc_id = SD_CMD16; sc_arg = BB32;
						end
					end else if (tail_q[7]) begin
						do_fin_init = 1'b1; fin_st = ST_BUS;
					end else if (ms_q > init_timeout_ms) begin
						do_fin_init = 1'b1; fin_st = ST_ACMD41;
					end else begin
						sc_cmd = 1'b1; sc_sel = 1'b1; sc_id = SD_CMD55;
					end
				end
				SD_CMD58: begin
					if (pend_q != ST_OK) begin
						do_fin_init = 1'b1; fin_st = pend_q;
					end else if (blk_q) begin
						do_fin_init = 1'b1; fin_st = ST_OK;
					end else begin
						sc_cmd = 1'b1; sc_sel = 1'b1; sc_id = SD_CMD16; sc_arg = BB32;
					end
				end
				SD_CMD16: begin
					do_fin_init = 1'b1;
					fin_st = (tail_q == 32'h0) ? ST_OK : ST_CMD16;
				end
				default: begin
					do_fin = 1'b1; fin_st = pend_q;
				end
				endcase
			end
			PH_TOKEN: begin
				if (rx_byte == 8'hFE) begin
					ph_n = PH_DATA; idx_n = '0;
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end else if (rx_byte != 8'hFF || ms_q > token_timeout_ms) begin
					pend_n = ST_TOKEN;
					if (cc == SD_CMD18) begin
						sc_cmd = 1'b1; sc_id = SD_CMD12;
					end else do_desel = 1'b1;
				end else begin
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end
			end
			PH_DATA: begin
				if (idx_q < BB) begin
					rr[0].action = ACT_PAY; rr[0].payload = rx_byte; n = 3'd1;
				end
				idx_n = idx_q + BW'(1);
				if (idx_n < BB2) begin
					rr[n[1:0]].action = ACT_XCHG; rr[n[1:0]].tx_byte = 8'hFF;
					n = n + 3'd1;
				end else begin
					left_n = left_q - 16'd1;
					if (cc != SD_CMD18) do_desel = 1'b1;
					else if (left_n != 16'd0) begin
						ms_n = '0; ph_n = PH_TOKEN;
						rr[n[1:0]].action = ACT_XCHG; rr[n[1:0]].tx_byte = 8'hFF;
						n = n + 3'd1;
					end else begin
						sc_cmd = 1'b1; sc_id = SD_CMD12;
					end
				end
			end
			PH_BUSY: begin
				if (rx_byte == 8'hFF) do_desel = 1'b1;
				else if (ms_q > busy_tmo) begin
					if (pend_q == ST_OK) pend_n = ST_TIMEOUT;
					do_desel = 1'b1;
				end else begin
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end
			end
			default: ph_n = PH_IDLE;
			endcase
		end
		endcase

		// R1 handling
		if (do_r1) begin
			unique case (cc)
			SD_CMD0, SD_CMD41, SD_CMD16: begin
				tail_n = {24'd0, r1v}; do_desel = 1'b1;
			end
			SD_CMD8: begin
				if (r1v[2]) begin
					v2_n = 1'b0; pend_n = ST_OK; do_desel = 1'b1;
				end else if (r1v == 8'h01) begin
					tail_n = '0; idx_n = '0; ph_n = PH_TAIL;
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end else begin
					pend_n = ST_PATTERN; do_desel = 1'b1;
				end
			end
			SD_CMD55: begin
				if (r1v[7]) do_desel = 1'b1;
				else begin
					sc_cmd = 1'b1; sc_id = SD_CMD41;
					sc_arg = v2_q ? 32'h40000000 : 32'h0;
				end
			end
			SD_CMD58: begin
				if (r1v != 8'h00) begin
					pend_n = ST_CMD58; do_desel = 1'b1;
				end else begin
					tail_n = '0; idx_n = '0; ph_n = PH_TAIL;
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end
			end
			SD_CMD17, SD_CMD18: begin
				if (r1v != 8'h00) begin
					pend_n = ST_READCMD; do_desel = 1'b1;
				end else begin
					ms_n = '0; ph_n = PH_TOKEN;
					rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
				end
			end
			SD_CMD12: begin
				ms_n = '0; ph_n = PH_BUSY;
				rr[0].action = ACT_XCHG; rr[0].tx_byte = 8'hFF; n = 3'd1;
			end
			default: do_desel = 1'b1;
			endcase
		end

		if (do_tail_chk) begin
			if (cc == SD_CMD8) begin
				if (tail_n[7:0] != 8'hAA) pend_n = ST_PATTERN;
				else if (tail_n[11:8] == 4'd0) pend_n = ST_VOLT;
				else begin
					pend_n = ST_OK; v2_n = 1'b1;
				end
			end else begin
				if (tail_n[21:20] == 2'd0) pend_n = ST_VOLT;
				else begin
					pend_n = ST_OK; blk_n = tail_n[30];
				end
			end
			do_desel = 1'b1;
		end

		if (do_desel) begin
			rr[n[1:0]].action = ACT_CS; n = n + 3'd1;
			rr[n[1:0]].action = ACT_XCHG; rr[n[1:0]].tx_byte = 8'hFF; n = n + 3'd1;
			ph_n = PH_DESEL;
		end

		if (sc_cmd) begin
			head = {2'b01, sc_id, sc_arg};
			frame_n = {head, crc7(head), 1'b1};
			idx_n = BW'(1);
			ph_n = PH_CMD_TX;
			if (sc_sel) begin
				rr[n[1:0]].action = ACT_CS; rr[n[1:0]].level = 1'b1; n = n + 3'd1;
			end
			rr[n[1:0]].action = ACT_XCHG; rr[n[1:0]].tx_byte = 8'hFF; n = n + 3'd1;
		end

		if (do_fin_init) begin
			rr[n[1:0]].action = ACT_SPD; rr[n[1:0]].level = 1'b1; n = n + 3'd1;
			if (fin_st == ST_OK) rdy_n = 1'b1;
			kind_rdy = rdy_n;
			do_fin = 1'b1;
		end

		if (do_fin) begin
			rr[n[1:0]].action = ACT_FIN;
			rr[n[1:0]].status = fin_st;
			rr[n[1:0]].card_kind = !kind_rdy ? 2'd0 : (!v2_n ? 2'd1 : (blk_n ? 2'd3 : 2'd2));
			n = n + 3'd1;
			ph_n = PH_IDLE;
		end

		res.n  = n;
		res.r0 = rr[0];
		res.r1 = rr[1];
		res.r2 = rr[2];
		res.r3 = rr[3];
	end
endmodule

### hw/rtl/sd_spi_host_init_and_block_read_top.sv
// Top level of the SPI-mode SD host sequencer: channels, config registers, result queue.
`timescale 1ns / 1ps
// Usage
// The input channel (in_valid / in_stall) carries one transaction per step:
// start init, start read, a byte received from the card, or a millisecond
// tick. Each transaction is decoded combinationally by the sequencer and yields
// zero to four result transactions (exchange byte, chip select, bus speed,
// payload byte, finished) on the output channel (out_valid / out_stall),
// the final one of a step marked by last.
// Output: the results of a transaction are written into a small result buffer
// when it is accepted, behind any already queued, and leave from its head one
// per cycle while out_stall is low.
// Throughput: one input transaction per cycle while the buffer has room for
// four more results; the buffer depth (eight entries) sets that figure.
// in_stall rises only when fewer than four free slots remain.
// Reset: arst_n clears the sequencer to idle, the card to uninitialised and
// the configuration registers to their defaults; the buffer is emptied.
// When the receiver stalls, the head result holds and new inputs are taken
// until fewer than four free slots remain; then in_stall rises.
// Configuration: write cfg_we / cfg_index / cfg_data only while idle.
module sd_spi_host_init_and_block_read_top #(
	parameter int BLOCK_BYTES   = sdspi_pkg::BLOCK_BYTES_DEF,
	parameter int POWERUP_BYTES = sdspi_pkg::POWERUP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] block_address,
	input  logic [15:0] block_count,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [7:0]  tx_byte,
	output logic        level,
	output logic [7:0]  payload,
	output logic [3:0]  status,
	output logic [1:0]  card_kind,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sdspi_pkg::*;

	typedef struct packed {
		res_t r;
		logic l;
	} qent_t;

	logic [7:0]  resp_lim_q, idle_att_q;
	logic [15:0] init_tmo_q, token_tmo_q, busy_tmo_q;
	res_set_t    rs;
	logic        step;
	qent_t       fifo_q [8];
	logic [2:0]  wr_q, rd_q;
	logic [3:0]  cnt_q;
	logic        pop;
	qent_t       head;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_lim_q  <= 8'd16;
			idle_att_q  <= 8'd16;
			init_tmo_q  <= 16'd1000;
			token_tmo_q <= 16'd200;
			busy_tmo_q  <= 16'd500;
		end else if (cfg_we) begin
			unique case (cfg_index)
			REG_RESP_LIMIT: resp_lim_q  <= cfg_data[7:0];
			REG_IDLE_TRIES: idle_att_q  <= cfg_data[7:0];
			REG_INIT_TMO:   init_tmo_q  <= cfg_data;
			REG_TOKEN_TMO:  token_tmo_q <= cfg_data;
			REG_BUSY_TMO:   busy_tmo_q  <= cfg_data;
			default: ;
			endcase
		end
	end

	// stall when a worst-case step might not fit
	assign in_stall = (cnt_q > 4'd4);
	assign step     = in_valid && !in_stall;

	sdspi_seq #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.POWERUP_BYTES(POWERUP_BYTES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.command(command),
		.block_address(block_address),
		.block_count(block_count),
		.rx_byte(rx_byte),
		.response_limit(resp_lim_q),
		.idle_attempts(idle_att_q),
		.init_timeout_ms(init_tmo_q),
		.token_timeout_ms(token_tmo_q),
		.busy_tmo(busy_tmo_q),
		.res(rs)
	);

	assign pop = out_valid && !out_stall;

	// push the step's results in order, mark the final one
	always_ff @(posedge clk) begin
		if (step) begin
			if (rs.n > 3'd0) fifo_q[wr_q]        <= '{r: rs.r0, l: rs.n == 3'd1};
			if (rs.n > 3'd1) fifo_q[wr_q + 3'd1] <= '{r: rs.r1, l: rs.n == 3'd2};
			if (rs.n > 3'd2) fifo_q[wr_q + 3'd2] <= '{r: rs.r2, l: rs.n == 3'd3};
			if (rs.n > 3'd3) fifo_q[wr_q + 3'd3] <= '{r: rs.r3, l: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (step) wr_q <= wr_q + rs.n;
			if (pop)  rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + (step ? {1'b0, rs.n} : 4'd0) - (pop ? 4'd1 : 4'd0);
		end
	end

	assign head      = fifo_q[rd_q];
	assign out_valid = (cnt_q != 4'd0);
	assign action    = head.r.action;
	assign tx_byte   = head.r.tx_byte;
	assign level     = head.r.level;
	assign payload   = head.r.payload;
	assign status    = head.r.status;
	assign card_kind = head.r.card_kind;
	assign last      = head.l;
endmodule

### tb/tb_top.sv
// Testbench for the SPI-mode SD host sequencer: card emulation, reference predictor, scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import sdspi_pkg::*;

	// ---------------------------------------------------------------- clock, reset, ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = CMD_TICK;
	logic [31:0] block_address = '0;
	logic [15:0] block_count = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [7:0]  tx_byte;
	logic        level;
	logic [7:0]  payload;
	logic [3:0]  status;
	logic [1:0]  card_kind;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	always #2 clk = ~clk;

	sd_spi_host_init_and_block_read_top uut (.*);

	// ---------------------------------------------------------------- predictor state
	typedef struct {
		res_t r;
		logic last;
	} want_t;

	want_t  want_q[$];     // results still owed by the block, oldest first
	res_t   step_res[$];   // results of the transaction being predicted

	phase_t      ph;
	int          bidx;
	logic [47:0] frame;
	logic [7:0]  tries, scans;
	logic [15:0] ms, left;
	logic [31:0] tail;
	logic        v2, blk, rdy;
	logic [3:0]  pend;
	logic [7:0]  lim_resp, lim_idle;
	logic [15:0] tmo_init, tmo_token, tmo_busy;

	int errors = 0;
	int n_checked = 0;
	int n_sent = 0;
	int n_counted = 0;
	int n_settings = 1;
	int card_sel = 0;      // emulated card: 0 v1, 1 v2 byte addressed, 2 v2 block addressed
	logic long_hold = 1'b0;

	function automatic logic [6:0] crc7_calc(input logic [39:0] head);
		logic [6:0] c;
		logic fb;
		c = '0;
		for (int i = 39; i >= 0; i--) begin
			fb = head[i] ^ c[6];
			c = {c[5:0], 1'b0};
			if (fb) c = c ^ 7'h09;
		end
		return c;
	endfunction

	function automatic void emit(input logic [2:0] a, input logic [7:0] tx, input logic lv,
			input logic [7:0] pay, input logic [3:0] st, input logic [1:0] k);
		res_t r;
		r.action = a; r.tx_byte = tx; r.level = lv; r.payload = pay; r.status = st;
		r.card_kind = k;
		step_res.push_back(r);
	endfunction

	function automatic void xchg(input logic [7:0] b);
		emit(ACT_XCHG, b, 1'b0, 8'h00, ST_OK, 2'd0);
	endfunction

	function automatic logic [1:0] kind_now();
		if (!rdy) return 2'd0;
		if (!v2) return 2'd1;
		return blk ? 2'd3 : 2'd2;
	endfunction

	function automatic logic [5:0] cmd_now();
		return frame[45:40];
	endfunction

	function automatic void finish_seq(input logic [3:0] st);
		emit(ACT_FIN, 8'h00, 1'b0, 8'h00, st, kind_now());
		ph = PH_IDLE;
	endfunction

	function automatic void issue_cmd(input logic [5:0] c, input logic [31:0] arg,
			input logic sel);
		logic [39:0] head;
		head = {2'b01, c, arg};
		frame = {head, crc7_calc(head), 1'b1};
		bidx = 1;
		ph = PH_CMD_TX;
		if (sel) emit(ACT_CS, 8'h00, 1'b1, 8'h00, ST_OK, 2'd0);
		xchg(8'hFF);
	endfunction

	function automatic void drop_cs();
		emit(ACT_CS, 8'h00, 1'b0, 8'h00, ST_OK, 2'd0);
		xchg(8'hFF);
		ph = PH_DESEL;
	endfunction

	function automatic void init_done(input logic [3:0] st);
		emit(ACT_SPD, 8'h00, 1'b1, 8'h00, ST_OK, 2'd0);
		if (st == ST_OK) rdy = 1'b1;
		finish_seq(st);
	endfunction

	function automatic void read_tail();
		tail = '0; bidx = 0; ph = PH_TAIL;
		xchg(8'hFF);
	endfunction

	function automatic void wait_token();
		ms = '0; ph = PH_TOKEN;
		xchg(8'hFF);
	endfunction

	function automatic void got_r1(input logic [7:0] r);
		case (cmd_now())
			SD_CMD0, SD_CMD41, SD_CMD16: begin
				tail = {24'd0, r}; drop_cs();
			end
			SD_CMD8: begin
				if (r[2]) begin
					v2 = 1'b0; pend = ST_OK; drop_cs();
				end else if (r == 8'h01) read_tail();
				else begin
					pend = ST_PATTERN; drop_cs();
				end
			end
			SD_CMD55: begin
				if (r[7]) drop_cs();
				else issue_cmd(SD_CMD41, v2 ? 32'h4000_0000 : 32'h0, 1'b0);
			end
			SD_CMD58: begin
				if (r != 0) begin
					pend = ST_CMD58; drop_cs();
				end else read_tail();
			end
			SD_CMD17, SD_CMD18: begin
				if (r != 0) begin
					pend = ST_READCMD; drop_cs();
				end else wait_token();
			end
			SD_CMD12: begin
				ms = '0; ph = PH_BUSY; xchg(8'hFF);
			end
			default: drop_cs();
		endcase
	endfunction

	function automatic void got_tail();
		if (cmd_now() == SD_CMD8) begin
			if (tail[7:0] != 8'hAA) pend = ST_PATTERN;
			else if ((tail & 32'h0F00) == 0) pend = ST_VOLT;
			else begin
				pend = ST_OK; v2 = 1'b1;
			end
		end else begin
			if ((tail & 32'h0030_0000) == 0) pend = ST_VOLT;
			else begin
				pend = ST_OK; blk = tail[30];
			end
		end
		drop_cs();
	endfunction

	function automatic void after_desel();
		case (cmd_now())
			SD_CMD0: begin
				if (tail == 32'h01) begin
					pend = ST_OK; issue_cmd(SD_CMD8, 32'h0000_01AA, 1'b1);
				end else begin
					tries = tries + 8'd1;
					if (tries >= ((lim_idle == 0) ? 8'd1 : lim_idle)) init_done(ST_CMD0);
					else issue_cmd(SD_CMD0, 32'h0, 1'b1);
				end
			end
			SD_CMD8: begin
				if (pend != ST_OK) init_done(pend);
				else begin
					ms = '0; issue_cmd(SD_CMD55, 32'h0, 1'b1);
				end
			end
			SD_CMD55: init_done(ST_BUS);
			SD_CMD41: begin
				if (tail == 0) begin
					if (v2) issue_cmd(SD_CMD58, 32'h0, 1'b1);
					else begin
						blk = 1'b0; issue_cmd(SD_CMD16, BLOCK_BYTES_DEF, 1'b1);
					end
				end else if (tail[7]) init_done(ST_BUS);
				else if (ms > tmo_init) init_done(ST_ACMD41);
				else issue_cmd(SD_CMD55, 32'h0, 1'b1);
			end
			SD_CMD58: begin
				if (pend != ST_OK) init_done(pend);
				else if (blk) init_done(ST_OK);
				else issue_cmd(SD_CMD16, BLOCK_BYTES_DEF, 1'b1);
			end
			SD_CMD16: init_done(tail == 0 ? ST_OK : ST_CMD16);
			default: finish_seq(pend);
		endcase
	endfunction

	function automatic void card_byte(input logic [7:0] b);
		case (ph)
			PH_POWERUP: begin
				if (bidx < POWERUP_BYTES_DEF) begin
					xchg(8'hFF); bidx++;
				end else begin
					tries = '0; issue_cmd(SD_CMD0, 32'h0, 1'b1);
				end
			end
			PH_CMD_TX: begin
				if (bidx < 7) begin
					xchg(frame[47 - 8 * (bidx - 1) -: 8]); bidx++;
				end else if (cmd_now() == SD_CMD12) begin
					ph = PH_STUFF; xchg(8'hFF);
				end else begin
					ph = PH_RESP; scans = '0; xchg(8'hFF);
				end
			end
			PH_STUFF: begin
				ph = PH_RESP; scans = '0; xchg(8'hFF);
			end
			PH_RESP: begin
				if (!b[7]) got_r1(b);
				else begin
					scans = scans + 8'd1;
					if (scans >= ((lim_resp == 0) ? 8'd1 : lim_resp)) got_r1(8'hFF);
					else xchg(8'hFF);
				end
			end
			PH_TAIL: begin
				tail = {tail[23:0], b}; bidx++;
				if (bidx < 4) xchg(8'hFF); else got_tail();
			end
			PH_DESEL: after_desel();
			PH_TOKEN: begin
				if (b == 8'hFE) begin
					ph = PH_DATA; bidx = 0; xchg(8'hFF);
				end else if (b != 8'hFF || ms > tmo_token) begin
					pend = ST_TOKEN;
					if (cmd_now() == SD_CMD18) issue_cmd(SD_CMD12, 32'h0, 1'b0);
					else drop_cs();
				end else xchg(8'hFF);
			end
			PH_DATA: begin
				if (bidx < BLOCK_BYTES_DEF) emit(ACT_PAY, 8'h00, 1'b0, b, ST_OK, 2'd0);
				bidx++;
				if (bidx < BLOCK_BYTES_DEF + 2) xchg(8'hFF);
				else begin
					left = left - 16'd1;
					if (cmd_now() != SD_CMD18) drop_cs();
					else if (left > 0) wait_token();
					else issue_cmd(SD_CMD12, 32'h0, 1'b0);
				end
			end
			PH_BUSY: begin
				if (b == 8'hFF) drop_cs();
				else if (ms > tmo_busy) begin
					if (pend == ST_OK) pend = ST_TIMEOUT;
					drop_cs();
				end else xchg(8'hFF);
			end
			default: ph = PH_IDLE;
		endcase
	endfunction

	// Advance the predictor by one accepted transaction; leave its results in step_res.
	function automatic void predict_step(input logic [1:0] c, input logic [31:0] lba,
			input logic [15:0] cnt, input logic [7:0] b);
		step_res.delete();
		if (c == CMD_TICK) begin
			if (ms != 16'hFFFF) ms = ms + 16'd1;
		end else if (c == CMD_BYTE) begin
			if (ph != PH_IDLE) card_byte(b);
		end else if (ph == PH_IDLE) begin
			if (c == CMD_INIT) begin
				v2 = 1'b0; blk = 1'b0; rdy = 1'b0; pend = ST_OK; tries = '0; ms = '0;
				emit(ACT_SPD, 8'h00, 1'b0, 8'h00, ST_OK, 2'd0);
				emit(ACT_CS, 8'h00, 1'b0, 8'h00, ST_OK, 2'd0);
				xchg(8'hFF);
				bidx = 1;
				ph = PH_POWERUP;
			end else if (cnt == 0) finish_seq(ST_PARAM);
			else if (!rdy) finish_seq(ST_NOINIT);
			else begin
				left = cnt; pend = ST_OK;
				issue_cmd(cnt == 1 ? SD_CMD17 : SD_CMD18, blk ? lba : lba * BLOCK_BYTES_DEF,
					1'b1);
			end
		end
	endfunction

	function automatic void model_reset();
		lim_resp = 8'd16; lim_idle = 8'd16; tmo_init = 16'd1000; tmo_token = 16'd200;
		tmo_busy = 16'd500;
		ph = PH_IDLE; bidx = 0; frame = '0; tries = '0; scans = '0; ms = '0; tail = '0;
		v2 = 1'b0; blk = 1'b0; rdy = 1'b0; left = '0; pend = ST_OK;
	endfunction

	// ---------------------------------------------------------------- card emulation
	// Pick the byte a healthy card of the chosen kind would return, with some noise.
	// The start token is rare so that most reads end early on a token error.
	function automatic logic [7:0] card_answer();
		int p;
		p = $urandom_range(0, 99);
		case (ph)
			PH_RESP: begin
				if (p >= 88) return 8'($urandom_range(0, 255));
				case (cmd_now())
					SD_CMD0:  return (p < 4) ? 8'h00 : 8'h01;
					SD_CMD8:  return (card_sel == 0) ? 8'h05 : 8'h01;
					SD_CMD55: return 8'h01;
					SD_CMD41: return (p < 45) ? 8'h00 : 8'h01;
					default:  return 8'h00;
				endcase
			end
			PH_TAIL: begin
				if (p >= 92) return 8'($urandom_range(0, 255));
				if (cmd_now() == SD_CMD8) begin
					case (bidx)
						2: return 8'h01;
						3: return 8'hAA;
						default: return 8'h00;
					endcase
				end
				case (bidx)
					0: return (card_sel == 2) ? 8'hC0 : 8'h80;
					1: return 8'hFF;
					default: return 8'h00;
				endcase
			end
			PH_TOKEN: begin
				if (p < 4) return 8'hFE;
				if (p < 80) return 8'hFF;
				return 8'($urandom_range(0, 255));
			end
			PH_BUSY:  return (p < 40) ? 8'hFF : 8'($urandom_range(0, 254));
			default:  return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------------------------------------------------------- sender
	// Offer one transaction, hold it until accepted, then predict its results.
	// A typed row supplies its own single finished result instead of the predictor's.
	task automatic send_item(input logic [1:0] c, input logic [31:0] lba, input logic [15:0] cnt,
			input logic [7:0] b, input logic typed = 1'b0, input logic [3:0] st = ST_OK);
		want_t w;
		in_valid <= 1'b1;
		command <= c;
		block_address <= lba;
		block_count <= cnt;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_counted++;
		n_sent++;
		predict_step(c, lba, cnt, b);
		if (typed) begin
			w.r = '0;
			w.r.action = ACT_FIN;
			w.r.status = st;
			w.last = 1'b1;
			want_q.push_back(w);
		end else begin
			foreach (step_res[i]) begin
				w.r = step_res[i];
				w.last = (i == step_res.size() - 1);
				want_q.push_back(w);
			end
		end
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every owed result is out, then let the sequencer settle.
	task automatic drain();
		pause_sender(1);
		while (want_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RESP_LIMIT: lim_resp = val[7:0];
			REG_IDLE_TRIES: lim_idle = val[7:0];
			REG_INIT_TMO:   tmo_init = val;
			REG_TOKEN_TMO:  tmo_token = val;
			default:        tmo_busy = val;
		endcase
	endtask

	task automatic set_regs(input logic [15:0] r0, r1, r2, r3, r4);
		write_reg(REG_RESP_LIMIT, r0);
		write_reg(REG_IDLE_TRIES, r1);
		write_reg(REG_INIT_TMO, r2);
		write_reg(REG_TOKEN_TMO, r3);
		write_reg(REG_BUSY_TMO, r4);
		n_settings++;
	endtask

	// Random traffic: mostly well-formed card conversations, some noise and ticks.
	// Stop once the quota is met and the sequencer is back at idle.
	task automatic random_run(input int quota, input logic squeeze);
		int start;
		int p;
		logic [15:0] cnt;
		start = n_counted;
		if (squeeze) long_hold = 1'b1;
		while (n_counted - start < quota || ph != PH_IDLE) begin
			p = $urandom_range(0, 99);
			if (ph == PH_IDLE) begin
				if (p < 6) send_item(CMD_TICK, $urandom, 16'($urandom), 8'($urandom));
				else if (p < 10) send_item(CMD_BYTE, $urandom, 16'($urandom), 8'($urandom));
				else if ((!rdy && p < 80) || p < 30) begin
					card_sel = $urandom_range(0, 2);
					send_item(CMD_INIT, $urandom, 16'($urandom), 8'($urandom));
				end else begin
					cnt = (p < 34) ? 16'd0 : (p < 70) ? 16'd1 : 16'($urandom_range(2, 3));
					send_item(CMD_READ, $urandom, cnt, 8'($urandom));
				end
			end else if (p < 8) send_item(CMD_TICK, $urandom, 16'($urandom), 8'($urandom));
			else if (p < 10) send_item(2'($urandom_range(0, 1)), $urandom, 16'($urandom),
				8'($urandom));
			else send_item(CMD_BYTE, $urandom, 16'($urandom), card_answer());
			pause_sender(gap_len());
		end
	endtask

	// ---------------------------------------------------------------- directed table
	typedef struct {
		logic [1:0]  c;
		logic [31:0] lba;
		logic [15:0] cnt;
		logic [7:0]  b;
		logic        typed;
		logic [3:0]  st;
	} row_t;

	row_t rows[] = '{
		'{CMD_TICK, 32'h0, 16'h0, 8'h00, 1'b0, ST_OK},          // tick while idle: nothing
		'{CMD_BYTE, 32'h0, 16'h0, 8'hFF, 1'b0, ST_OK},          // stray byte while idle
		'{CMD_READ, 32'hFFFF_FFFF, 16'h0, 8'h00, 1'b1, ST_PARAM},
		'{CMD_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, ST_NOINIT},
		'{CMD_READ, 32'h0, 16'h1, 8'h00, 1'b1, ST_NOINIT},
		'{CMD_INIT, 32'h0, 16'h0, 8'h00, 1'b0, ST_OK},
		'{CMD_INIT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b0, ST_OK}, // busy: ignored
		'{CMD_READ, 32'h1234_5678, 16'h2, 8'h00, 1'b0, ST_OK},  // busy: ignored
		'{CMD_TICK, 32'h0, 16'h0, 8'h00, 1'b0, ST_OK},
		'{CMD_BYTE, 32'h0, 16'h0, 8'h00, 1'b0, ST_OK},
		'{CMD_BYTE, 32'h0, 16'h0, 8'hFF, 1'b0, ST_OK},
		'{CMD_BYTE, 32'h0, 16'h0, 8'h55, 1'b0, ST_OK},
		'{CMD_BYTE, 32'h0, 16'h0, 8'hAA, 1'b0, ST_OK}
	};

	// ---------------------------------------------------------------- receiver stall
	// Random short and long stalls; one long hold-off on request so the buffer fills.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold === 1'b1 && n_sent > 0) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				n_sent = -1000000;  // once only
			end
			n = gap_len();
			out_stall <= (n > 0);
			repeat ((n > 0) ? n : $urandom_range(1, 6)) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- scoreboard
	always @(posedge clk) begin
		want_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (want_q.size() == 0) begin
				$error("unexpected result transaction: action %0d", action);
				errors++;
			end else begin
				w = want_q.pop_front();
				n_checked++;
				if (action !== w.r.action) begin
					$error("action: expected %0d, got %0d", w.r.action, action); errors++;
				end
				if (tx_byte !== w.r.tx_byte) begin
					$error("tx_byte: expected %h, got %h", w.r.tx_byte, tx_byte); errors++;
				end
				if (level !== w.r.level) begin
					$error("level: expected %b, got %b", w.r.level, level); errors++;
				end
				if (payload !== w.r.payload) begin
					$error("payload: expected %h, got %h", w.r.payload, payload); errors++;
				end
				if (status !== w.r.status) begin
					$error("status: expected %0d, got %0d", w.r.status, status); errors++;
				end
				if (card_kind !== w.r.card_kind) begin
					$error("card_kind: expected %0d, got %0d", w.r.card_kind, card_kind); errors++;
				end
				if (last !== w.last) begin
					$error("last: expected %b, got %b", w.last, last); errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	initial begin
		#20_000_000;
		$display("sd_spi_host_init_and_block_read_top test failed");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence
	initial begin
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows, then random traffic continues the init they started
		foreach (rows[i]) begin
			send_item(rows[i].c, rows[i].lba, rows[i].cnt, rows[i].b, rows[i].typed, rows[i].st);
			pause_sender(gap_len());
		end
		random_run(60, 1'b1);
		drain();

		// low extremes: every wait expires fast
		set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		random_run(50, 1'b0);
		drain();

		// high extremes: timers never expire
		set_regs(16'd255, 16'd255, 16'd65535, 16'd65535, 16'd65535);
		random_run(50, 1'b0);
		drain();

		// zero limits behave as one
		set_regs(16'd0, 16'd0, 16'd20, 16'd4, 16'd3);
		random_run(50, 1'b0);
		drain();

		set_regs(16'd4, 16'd3, 16'd300, 16'd50, 16'd40);
		random_run(50, 1'b0);
		drain();

		repeat (20) @(posedge clk);
		$display("Ran %0d input transactions over %0d register settings;", n_counted,
			n_settings);
		$display("%0d result transactions compared, %0d mismatches.", n_checked, errors);
		if (errors == 0 && want_q.size() == 0) begin
			$display("sd_spi_host_init_and_block_read_top test passed");
		end else begin
			$display("sd_spi_host_init_and_block_read_top test failed");
		end
		$finish;
	end
endmodule

### sd_spi_host_init_and_block_read_top.f
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_seq.sv
hw/rtl/sd_spi_host_init_and_block_read_top.sv
tb/tb_top.sv
